>>> design/assert_macros.svh
// Assertion macros used by the rotator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define IQR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define IQR_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> design/iqr_pkg.sv
// Types and constants of the quarter-turn image rotator.
package iqr_pkg;

    localparam int SIZE_W     = 9;
    localparam int SIZE_MAX   = (1 << SIZE_W) - 1;
    localparam int PIX_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_ROWS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_COLS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_TURNS = 2'd2;

    localparam logic [1:0] TURN_0   = 2'd0;
    localparam logic [1:0] TURN_90  = 2'd1;
    localparam logic [1:0] TURN_180 = 2'd2;
    localparam logic [1:0] TURN_270 = 2'd3;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic   mode;
        pixel_t pixel_in;
    } in_word_t;

    typedef struct packed {
        pixel_t              pixel_out;
        logic                last_pixel;
        logic [SIZE_W-1:0]   out_rows;
        logic [SIZE_W-1:0]   out_cols;
    } out_word_t;

endpackage

>>> design/iqr_frame_store.sv
// Frame store: one write port, one read port with registered read data.
module iqr_frame_store #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  iqr_pkg::pixel_t       wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output iqr_pkg::pixel_t       rd_data
);

    iqr_pkg::pixel_t mem [DEPTH];
    iqr_pkg::pixel_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/image_quarter_turn_rotator_top.sv
// Quarter-turn image rotator top level.
// Throughput: one word per cycle, loads and readouts alike, while m_ready stays high.
// Load: the pixel goes into the frame store at its rotated address in the accept cycle.
// Readout: the result passes through the store read register and then the output register.
// Reset (aresetn low, synchronous): sizes 1x1, no rotation, empty frame, no result pending.
`include "assert_macros.svh"

module image_quarter_turn_rotator_top #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [iqr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [iqr_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  iqr_pkg::in_word_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output iqr_pkg::out_word_t                  m_data
);

    localparam int SIZE_W   = iqr_pkg::SIZE_W;
    localparam int ROWS_CAP = (MAX_ROWS < iqr_pkg::SIZE_MAX) ? MAX_ROWS : iqr_pkg::SIZE_MAX;
    localparam int COLS_CAP = (MAX_COLS < iqr_pkg::SIZE_MAX) ? MAX_COLS : iqr_pkg::SIZE_MAX;
    localparam int RS_W     = $clog2(ROWS_CAP + 1);
    localparam int CS_W     = $clog2(COLS_CAP + 1);
    localparam int RC_W     = (ROWS_CAP > 1) ? $clog2(ROWS_CAP) : 1;
    localparam int CC_W     = (COLS_CAP > 1) ? $clog2(COLS_CAP) : 1;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W   = RS_W + CS_W;
    localparam int IDX_W    = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;

    // configuration, stored already clamped to the legal size range
    logic [RS_W-1:0]   rows_reg, rows_next;
    logic [CS_W-1:0]   cols_reg, cols_next;
    logic [1:0]        turns_reg, turns_next;
    logic [IDX_W-1:0]  total_m1_reg, total_m1_next;

    logic [RC_W-1:0]   load_row_reg, load_row_next;
    logic [CC_W-1:0]   load_col_reg, load_col_next;
    logic              frame_complete_reg, frame_complete_next;
    logic [IDX_W-1:0]  read_index_reg, read_index_next;

    // read in flight: store data arrives in the cycle after the read
    logic              p_valid_reg, p_valid_next;
    logic              p_last_reg, p_last_next;
    logic [SIZE_W-1:0] p_rows_reg, p_rows_next;
    logic [SIZE_W-1:0] p_cols_reg, p_cols_next;

    logic                m_valid_reg, m_valid_next;
    iqr_pkg::out_word_t  m_data_reg, m_data_next;

    logic              in_load, in_read, rd_en, p_drain, cfg_hit;
    logic [RC_W-1:0]   rows_m1, row_flip;
    logic [CC_W-1:0]   cols_m1, col_flip;
    logic              row_last, col_last;
    logic [IDX_W-1:0]  fac, stride, offset, wr_addr_full;
    iqr_pkg::pixel_t   rd_data;

    function automatic logic [RS_W-1:0] clamp_rows(input logic [SIZE_W-1:0] v);
        if (v == '0) begin
            return RS_W'(1);
        end else if (32'(v) > 32'(MAX_ROWS)) begin
            return RS_W'(MAX_ROWS);
        end else begin
            return RS_W'(v);
        end
    endfunction

    function automatic logic [CS_W-1:0] clamp_cols(input logic [SIZE_W-1:0] v);
        if (v == '0) begin
            return CS_W'(1);
        end else if (32'(v) > 32'(MAX_COLS)) begin
            return CS_W'(MAX_COLS);
        end else begin
            return CS_W'(v);
        end
    endfunction

    assign s_ready = !p_valid_reg || !m_valid_reg || m_ready;
    assign in_load = s_valid && s_ready && (s_data.mode == iqr_pkg::MODE_LOAD);
    assign in_read = s_valid && s_ready && (s_data.mode == iqr_pkg::MODE_READ);
    assign rd_en   = in_read && frame_complete_reg;
    assign p_drain = p_valid_reg && (!m_valid_reg || m_ready);

    assign rows_m1  = RC_W'(rows_reg - RS_W'(1));
    assign cols_m1  = CC_W'(cols_reg - CS_W'(1));
    assign row_flip = rows_m1 - load_row_reg;
    assign col_flip = cols_m1 - load_col_reg;
    assign row_last = (load_row_reg == rows_m1);
    assign col_last = (load_col_reg == cols_m1);

    // rotated store address = fac * stride + offset
    always_comb begin
        case (turns_reg)
            iqr_pkg::TURN_0: begin
                fac    = IDX_W'(load_row_reg);
                stride = IDX_W'(cols_reg);
                offset = IDX_W'(load_col_reg);
            end
            iqr_pkg::TURN_90: begin
                fac    = IDX_W'(load_col_reg);
                stride = IDX_W'(rows_reg);
                offset = IDX_W'(row_flip);
            end
            iqr_pkg::TURN_180: begin
                fac    = IDX_W'(row_flip);
                stride = IDX_W'(cols_reg);
                offset = IDX_W'(col_flip);
            end
            default: begin
                fac    = IDX_W'(col_flip);
                stride = IDX_W'(rows_reg);
                offset = IDX_W'(load_row_reg);
            end
        endcase
        wr_addr_full = fac * stride + offset;
    end

    assign cfg_hit = cfg_wr_en && (cfg_index == iqr_pkg::CFG_SRC_ROWS ||
                                   cfg_index == iqr_pkg::CFG_SRC_COLS ||
                                   cfg_index == iqr_pkg::CFG_QUARTER_TURNS);

    always_comb begin
        rows_next           = rows_reg;
        cols_next           = cols_reg;
        turns_next          = turns_reg;
        total_m1_next       = IDX_W'(IDX_W'(rows_reg) * IDX_W'(cols_reg) - IDX_W'(1));
        load_row_next       = load_row_reg;
        load_col_next       = load_col_reg;
        frame_complete_next = frame_complete_reg;
        read_index_next     = read_index_reg;

        if (in_load) begin
            // a load on a complete frame starts a new one; counters are already at zero
            frame_complete_next = row_last && col_last;
            read_index_next     = '0;
            if (col_last) begin
                load_col_next = '0;
                load_row_next = row_last ? '0 : load_row_reg + RC_W'(1);
            end else begin
                load_col_next = load_col_reg + CC_W'(1);
            end
        end

        if (rd_en) begin
            read_index_next = (read_index_reg == total_m1_reg) ? '0
                                                               : read_index_reg + IDX_W'(1);
        end

        // any write to a defined register abandons the frame
        if (cfg_hit) begin
            case (cfg_index)
                iqr_pkg::CFG_SRC_ROWS:      rows_next  = clamp_rows(cfg_wr_data);
                iqr_pkg::CFG_SRC_COLS:      cols_next  = clamp_cols(cfg_wr_data);
                iqr_pkg::CFG_QUARTER_TURNS: turns_next = cfg_wr_data[1:0];
                default: ;
            endcase
            load_row_next       = '0;
            load_col_next       = '0;
            frame_complete_next = 1'b0;
            read_index_next     = '0;
        end
    end

    always_comb begin
        p_valid_next = p_valid_reg;
        p_last_next  = p_last_reg;
        p_rows_next  = p_rows_reg;
        p_cols_next  = p_cols_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (p_drain) begin
            m_valid_next           = 1'b1;
            m_data_next.pixel_out  = rd_data;
            m_data_next.last_pixel = p_last_reg;
            m_data_next.out_rows   = p_rows_reg;
            m_data_next.out_cols   = p_cols_reg;
            p_valid_next           = 1'b0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (rd_en) begin
            p_valid_next = 1'b1;
            p_last_next  = (read_index_reg == total_m1_reg);
            p_rows_next  = turns_reg[0] ? SIZE_W'(cols_reg) : SIZE_W'(rows_reg);
            p_cols_next  = turns_reg[0] ? SIZE_W'(rows_reg) : SIZE_W'(cols_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg           <= RS_W'(1);
            cols_reg           <= CS_W'(1);
            turns_reg          <= iqr_pkg::TURN_0;
            total_m1_reg       <= '0;
            load_row_reg       <= '0;
            load_col_reg       <= '0;
            frame_complete_reg <= 1'b0;
            read_index_reg     <= '0;
            p_valid_reg        <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            rows_reg           <= rows_next;
            cols_reg           <= cols_next;
            turns_reg          <= turns_next;
            total_m1_reg       <= total_m1_next;
            load_row_reg       <= load_row_next;
            load_col_reg       <= load_col_next;
            frame_complete_reg <= frame_complete_next;
            read_index_reg     <= read_index_next;
            p_valid_reg        <= p_valid_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_last_reg <= p_last_next;
        p_rows_reg <= p_rows_next;
        p_cols_reg <= p_cols_next;
        m_data_reg <= m_data_next;
    end

    iqr_frame_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (in_load),
        .wr_addr (wr_addr_full[ADDR_W-1:0]),
        .wr_data (s_data.pixel_in),
        .rd_en   (rd_en),
        .rd_addr (read_index_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `IQR_ASSERT(a_stall_blocks_input, p_valid_reg && m_valid_reg && !m_ready |-> !s_ready, "read in flight would be overwritten")
    `IQR_ASSERT(a_no_early_result, in_read && !frame_complete_reg |=> !p_valid_reg, "result for a readout of an incomplete frame")
    `IQR_ASSERT(a_load_in_range, load_row_reg < rows_reg && load_col_reg < cols_reg, "load position outside the source image")
    `IQR_ASSERT(a_complete_at_origin, frame_complete_reg |-> load_row_reg == '0 && load_col_reg == '0, "complete frame with load counters not at origin")
    `IQR_ASSERT(a_read_in_range, read_index_reg <= total_m1_reg, "read index past the end of the frame")
    `IQR_ASSERT_RST(a_reset_clears, !aresetn |=> !m_valid_reg && !p_valid_reg && !frame_complete_reg, "reset left a word pending")

endmodule
